// File: design/wsfp_pkg.sv
// Shared types and constants for the WebSocket frame parser.
// Frame kind codes, opcode values, length field codes and header byte counts; no dependencies.
package wsfp_pkg;

   // Frame kind codes reported on the closing beat of a frame
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_TEXT           = 3'd0;
   localparam kind_type KIND_TEXT_PARTIAL   = 3'd1;
   localparam kind_type KIND_BINARY         = 3'd2;
   localparam kind_type KIND_BINARY_PARTIAL = 3'd3;
   localparam kind_type KIND_CLOSE          = 3'd4;
   localparam kind_type KIND_PING           = 3'd5;
   localparam kind_type KIND_PONG           = 3'd6;
   localparam kind_type KIND_ERROR          = 3'd7;

   // Opcodes from the first header byte
   typedef logic [3:0] opcode_type;
   localparam opcode_type OP_CONT   = 4'h0;
   localparam opcode_type OP_TEXT   = 4'h1;
   localparam opcode_type OP_BINARY = 4'h2;
   localparam opcode_type OP_CLOSE  = 4'h8;
   localparam opcode_type OP_PING   = 4'h9;
   localparam opcode_type OP_PONG   = 4'hA;

   // Seven-bit length field codes
   localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
   localparam logic [6:0] LEN7_EXT16     = 7'd126;

   // Extended length and key byte counts
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// File: design/websocket_frame_parser_unit.sv
// WebSocket frame parser: one received byte per beat in, unmasked payload out.
// A result is registered: it is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; input stalls only while a result waits on rsp_tready.
// Header bytes give no result except the closing beat of a zero-length frame.
// Reset (synchronous, active high) returns the parser to the first header byte
// and clears all frame state and the output register.
module websocket_frame_parser_unit #(
   parameter int LENGTH_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   // input stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic [7:0] rsp_tuser,   // [0] byte_valid, [3:1] frame_kind, [7:4] zero
   output logic       rsp_tlast    // frame_end
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_KEY,
      PH_DATA
   } phase_type;

   // Parser state
   phase_type                  phase_ff, phase_in;
   wsfp_pkg::opcode_type       opcode_ff, opcode_in;
   logic                       final_ff, final_in;
   logic                       masked_ff, masked_in;
   logic [3:0]                 hdr_left_ff, hdr_left_in;
   logic [LENGTH_BITS-1:0]     remain_ff, remain_in;
   logic [3:0][7:0]            key_ff, key_in;
   logic [1:0]                 key_idx_ff, key_idx_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_data_ff, rsp_data_in;
   logic                       rsp_bvalid_ff, rsp_bvalid_in;
   logic                       rsp_end_ff, rsp_end_in;
   wsfp_pkg::kind_type         rsp_kind_ff, rsp_kind_in;

   // Per-beat result
   logic                       res_valid;
   logic [7:0]                 res_data;
   logic                       res_bvalid;
   logic                       res_end;

   logic                       req_accept;
   logic [6:0]                 len7;
   logic                       len_done;
   logic [LENGTH_BITS-1:0]     len_value;
   logic [3:0]                 hdr_dec;
   logic [1:0]                 key_wr_idx;
   logic [7:0]                 key_byte;
   wsfp_pkg::kind_type         kind;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign len7       = req_tdata[6:0];
   assign hdr_dec    = hdr_left_ff - 4'd1;
   assign key_wr_idx = 2'(wsfp_pkg::KEY_BYTES - hdr_left_ff);
   assign key_byte   = masked_ff ? key_ff[key_idx_ff] : 8'h00;

   // Frame kind from the stored opcode and final bit
   always_comb begin
      case (opcode_ff)
         wsfp_pkg::OP_CONT,
         wsfp_pkg::OP_TEXT:   kind = final_ff ? wsfp_pkg::KIND_TEXT
                                              : wsfp_pkg::KIND_TEXT_PARTIAL;
         wsfp_pkg::OP_BINARY: kind = final_ff ? wsfp_pkg::KIND_BINARY
                                              : wsfp_pkg::KIND_BINARY_PARTIAL;
         wsfp_pkg::OP_CLOSE:  kind = wsfp_pkg::KIND_CLOSE;
         wsfp_pkg::OP_PING:   kind = wsfp_pkg::KIND_PING;
         wsfp_pkg::OP_PONG:   kind = wsfp_pkg::KIND_PONG;
         default:             kind = wsfp_pkg::KIND_ERROR;
      endcase
   end

   // Next state and result for the accepted beat
   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      final_in    = final_ff;
      masked_in   = masked_ff;
      hdr_left_in = hdr_left_ff;
      remain_in   = remain_ff;
      key_in      = key_ff;
      key_idx_in  = key_idx_ff;
      res_valid   = 1'b0;
      res_data    = 8'h00;
      res_bvalid  = 1'b0;
      res_end     = 1'b0;
      len_done    = 1'b0;
      len_value   = remain_ff;

      if (req_accept) begin
         case (phase_ff)
            PH_HDR1: begin
               masked_in = req_tdata[7];
               remain_in = '0;
               if (len7 <= wsfp_pkg::LEN7_MAX_SHORT) begin
                  len_done  = 1'b1;
                  len_value = LENGTH_BITS'(len7);
               end else begin
                  hdr_left_in = (len7 == wsfp_pkg::LEN7_EXT16) ? wsfp_pkg::EXT16_BYTES
                                                               : wsfp_pkg::EXT64_BYTES;
                  phase_in    = PH_EXTLEN;
               end
            end
            PH_EXTLEN: begin
               // saturate once the top byte is occupied
               if (|remain_ff[LENGTH_BITS-1:LENGTH_BITS-8]) begin
                  len_value = '1;
               end else begin
                  len_value = {remain_ff[LENGTH_BITS-9:0], req_tdata};
               end
               remain_in   = len_value;
               hdr_left_in = hdr_dec;
               len_done    = (hdr_dec == 4'd0);
            end
            PH_KEY: begin
               key_in[key_wr_idx] = req_tdata;
               hdr_left_in        = hdr_dec;
               if (hdr_dec == 4'd0) begin
                  key_idx_in = 2'd0;
                  if (remain_ff == '0) begin
                     phase_in  = PH_HDR0;
                     res_valid = 1'b1;
                     res_end   = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               key_idx_in = key_idx_ff + 2'd1;
               remain_in  = remain_ff - LENGTH_BITS'(1);
               res_valid  = 1'b1;
               res_bvalid = 1'b1;
               res_data   = req_tdata ^ key_byte;
               res_end    = (remain_ff == LENGTH_BITS'(1));
               if (res_end) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               opcode_in = req_tdata[3:0];
               final_in  = req_tdata[7];
               phase_in  = PH_HDR1;
            end
         endcase

         // length known: key, payload, or close an empty frame
         if (len_done) begin
            remain_in  = len_value;
            key_idx_in = 2'd0;
            if (masked_in) begin
               phase_in    = PH_KEY;
               hdr_left_in = wsfp_pkg::KEY_BYTES;
            end else begin
               hdr_left_in = 4'd0;
               if (len_value == '0) begin
                  phase_in  = PH_HDR0;
                  res_valid = 1'b1;
                  res_end   = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
      end
   end

   // Output register next values
   always_comb begin
      rsp_data_in   = rsp_data_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_kind_in   = rsp_kind_ff;
      if (req_accept && res_valid) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = res_data;
         rsp_bvalid_in = res_bvalid;
         rsp_end_in    = res_end;
         rsp_kind_in   = res_end ? kind : wsfp_pkg::KIND_TEXT;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         opcode_ff     <= wsfp_pkg::OP_CONT;
         final_ff      <= 1'b0;
         masked_ff     <= 1'b0;
         hdr_left_ff   <= 4'd0;
         remain_ff     <= '0;
         key_ff        <= '0;
         key_idx_ff    <= 2'd0;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= 8'h00;
         rsp_bvalid_ff <= 1'b0;
         rsp_end_ff    <= 1'b0;
         rsp_kind_ff   <= wsfp_pkg::KIND_TEXT;
      end else begin
         phase_ff      <= phase_in;
         opcode_ff     <= opcode_in;
         final_ff      <= final_in;
         masked_ff     <= masked_in;
         hdr_left_ff   <= hdr_left_in;
         remain_ff     <= remain_in;
         key_ff        <= key_in;
         key_idx_ff    <= key_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_bvalid_ff <= rsp_bvalid_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_kind_ff   <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {4'd0, rsp_kind_ff, rsp_bvalid_ff};
   assign rsp_tlast  = rsp_end_ff;

endmodule

// File: design/wsfp_checker.sv
// Port-level checks for the WebSocket frame parser, bound to its top level.
// Sees only the top-level ports; no package dependency.
module wsfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [7:0] rsp_tuser,
   input logic       rsp_tlast
);

   // a beat without payload carries zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'h00)
      else $error("data-less beat has nonzero data");

   // a data-less beat only ever closes a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("data-less beat does not close a frame");

   // kind is zero except on the closing beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[3:1] == 3'd0)
      else $error("frame kind set on a non-closing beat");

   // input is never blocked while the output register is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                   && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind websocket_frame_parser_unit wsfp_checker u_wsfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
